### rtl/rbol_pkg.sv
// Shared types and constants for the ring buffer offset lookup block.
// Used by the controller, the datapath and the top level. No dependencies.
package rbol_pkg;

  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 16;
  localparam int OFFS_W   = 20;
  localparam int SLOT_W   = 4;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_WALK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic add_commit;
    logic step;
    logic cap_hit;
    logic cap_miss;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_null;
    logic is_hit;
    logic is_last;
    logic out_free;
  } stat_t;

endpackage

### rtl/rbol_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbol_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rbol_ctrl.sv
// Controller state machine for the ring buffer offset lookup.
// Depends on rbol_pkg; drives datapath commands from its status.
module rbol_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_operation,
  output logic           in_stall,
  input  rbol_pkg::stat_t stat,
  output rbol_pkg::cmd_t  cmd
);

  rbol_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbol_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      rbol_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_operation == rbol_pkg::OP_FIND) ? rbol_pkg::ST_WALK
                                                           : rbol_pkg::ST_ADD;
        end
      end
      rbol_pkg::ST_ADD: begin
        cmd.add_commit = 1'b1;
        state_nxt      = rbol_pkg::ST_RESP;
      end
      rbol_pkg::ST_WALK: begin
        // null entry ends the walk before any length test
        if (stat.is_null) begin
          cmd.cap_miss = 1'b1;
          state_nxt    = rbol_pkg::ST_RESP;
        end else if (stat.is_hit) begin
          cmd.cap_hit = 1'b1;
          state_nxt   = rbol_pkg::ST_RESP;
        end else if (stat.is_last) begin
          cmd.cap_miss = 1'b1;
          state_nxt    = rbol_pkg::ST_RESP;
        end else begin
          cmd.step = 1'b1;
        end
      end
      rbol_pkg::ST_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = rbol_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rbol_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/rbol_dp.sv
// Datapath: ring indices, descriptor RAM with valid bits, walk accumulator,
// result and output registers. Depends on rbol_pkg and rbol_ram.
module rbol_dp #(
  parameter int RING_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rbol_pkg::cmd_t                  cmd,
  output rbol_pkg::stat_t                 stat,
  input  logic                            in_operation,
  input  logic [rbol_pkg::HANDLE_W-1:0]   in_entry_handle,
  input  logic [rbol_pkg::SIZE_W-1:0]     in_entry_size,
  input  logic [rbol_pkg::OFFS_W-1:0]     in_lookup_offset,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic [rbol_pkg::SLOT_W-1:0]     out_slot,
  output logic [rbol_pkg::HANDLE_W-1:0]   out_found_handle,
  output logic [rbol_pkg::SIZE_W-1:0]     out_found_size,
  output logic [rbol_pkg::SIZE_W-1:0]     out_byte_offset,
  output logic                            out_evicted,
  output logic [rbol_pkg::HANDLE_W-1:0]   out_evicted_handle
);

  localparam int IDX_W   = $clog2(RING_DEPTH);
  localparam int ENTRY_W = rbol_pkg::HANDLE_W + rbol_pkg::SIZE_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

  logic [IDX_W-1:0] wr_idx_r, rd_idx_r, pos_r, cnt_r;
  logic [IDX_W-1:0] wr_inc, rd_inc, pos_inc, rd_idx_nxt, pos_nxt;
  logic             full_r;
  logic [RING_DEPTH-1:0] vld_r;
  logic             rd_vld_r;

  logic [rbol_pkg::OFFS_W-1:0]   offs_r, total_r;
  logic [rbol_pkg::OFFS_W:0]     sum;
  logic [rbol_pkg::HANDLE_W-1:0] add_handle_r;
  logic [rbol_pkg::SIZE_W-1:0]   add_size_r;

  rbol_pkg::entry_t              rdata, wdata;
  logic [rbol_pkg::HANDLE_W-1:0] cur_handle;
  logic [rbol_pkg::SIZE_W-1:0]   cur_len;

  logic                          res_hit_r, res_evicted_r;
  logic [rbol_pkg::SLOT_W-1:0]   res_slot_r;
  logic [rbol_pkg::HANDLE_W-1:0] res_fh_r, res_eh_r;
  logic [rbol_pkg::SIZE_W-1:0]   res_fs_r, res_bo_r;
  logic                          out_valid_r;

  assign wr_inc  = (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + IDX_W'(1);
  assign rd_inc  = (rd_idx_r == IDX_LAST) ? '0 : rd_idx_r + IDX_W'(1);
  assign pos_inc = (pos_r == IDX_LAST) ? '0 : pos_r + IDX_W'(1);
  assign rd_idx_nxt = full_r ? rd_inc : rd_idx_r;

  // RAM is addressed with the next walk position so its data lines up with pos_r
  always_comb begin
    pos_nxt = pos_r;
    if (cmd.load) begin
      pos_nxt = (in_operation == rbol_pkg::OP_FIND) ? rd_idx_r : wr_idx_r;
    end else if (cmd.step) begin
      pos_nxt = pos_inc;
    end
  end

  assign wdata.handle = add_handle_r;
  assign wdata.size   = add_size_r;

  rbol_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.add_commit),
    .waddr (wr_idx_r),
    .wdata (wdata),
    .raddr (pos_nxt),
    .rdata (rdata)
  );

  // never-written slots read as null / zero length
  assign cur_handle = rd_vld_r ? rdata.handle : '0;
  assign cur_len    = rd_vld_r ? rdata.size : '0;
  assign sum        = {1'b0, total_r} + (rbol_pkg::OFFS_W + 1)'(cur_len);

  assign stat.is_null  = (cur_handle == '0);
  assign stat.is_hit   = (sum > {1'b0, offs_r});
  assign stat.is_last  = (cnt_r == IDX_LAST);
  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      full_r      <= 1'b0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      rd_vld_r <= vld_r[pos_nxt];
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.step) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      if (cmd.add_commit) begin
        vld_r[wr_idx_r] <= 1'b1;
        wr_idx_r        <= wr_inc;
        rd_idx_r        <= rd_idx_nxt;
        full_r          <= (wr_inc == rd_idx_nxt);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      offs_r       <= in_lookup_offset;
      total_r      <= '0;
      add_handle_r <= in_entry_handle;
      add_size_r   <= in_entry_size;
    end else if (cmd.step) begin
      total_r <= sum[rbol_pkg::OFFS_W-1:0];
    end

    if (cmd.add_commit) begin
      res_hit_r     <= 1'b0;
      res_slot_r    <= '0;
      res_fh_r      <= '0;
      res_fs_r      <= '0;
      res_bo_r      <= '0;
      res_evicted_r <= full_r;
      res_eh_r      <= full_r ? cur_handle : '0;
    end else if (cmd.cap_hit) begin
      res_hit_r     <= 1'b1;
      res_slot_r    <= rbol_pkg::SLOT_W'(pos_r);
      res_fh_r      <= cur_handle;
      res_fs_r      <= cur_len;
      res_bo_r      <= rbol_pkg::SIZE_W'(offs_r - total_r);
      res_evicted_r <= 1'b0;
      res_eh_r      <= '0;
    end else if (cmd.cap_miss) begin
      res_hit_r     <= 1'b0;
      res_slot_r    <= '0;
      res_fh_r      <= '0;
      res_fs_r      <= '0;
      res_bo_r      <= '0;
      res_evicted_r <= 1'b0;
      res_eh_r      <= '0;
    end

    if (cmd.out_load) begin
      out_hit            <= res_hit_r;
      out_slot           <= res_slot_r;
      out_found_handle   <= res_fh_r;
      out_found_size     <= res_fs_r;
      out_byte_offset    <= res_bo_r;
      out_evicted        <= res_evicted_r;
      out_evicted_handle <= res_eh_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/ring_buffer_offset_lookup.sv
// Ring buffer of entry descriptors with byte-offset lookup.
// Input channel (in_*): operation 0 adds {entry_handle, entry_size} at the
//   write index, overwriting the oldest entry when the ring is full;
//   operation 1 finds the entry that holds byte lookup_offset of the entries
//   concatenated from oldest to newest, up to the first null handle.
// Result channel (out_*): one item per input item; find fields are zero on
//   an add, eviction fields are zero on a find, all find fields zero on miss.
// Both channels: item moves on a clock edge with valid high and stall low.
// Sequence: an add passes through ST_ADD and ST_RESP after acceptance; a find
//   walks k = 1..RING_DEPTH slots, one slot per cycle through the single
//   read port of the descriptor RAM, then passes through ST_RESP. One item is
//   in work at a time.
// If the receiver stalls, the result holds in the output register; the block
//   takes one more item, works it, and holds its result until the output
//   register frees, stalling the input meanwhile.
// Reset (rst_n low, synchronous) empties the ring: indices go to zero and
//   per-slot valid bits clear, so every slot reads as a null entry.
module ring_buffer_offset_lookup #(
  parameter int RING_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [rbol_pkg::HANDLE_W-1:0] in_entry_handle,
  input  logic [rbol_pkg::SIZE_W-1:0]   in_entry_size,
  input  logic [rbol_pkg::OFFS_W-1:0]   in_lookup_offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [rbol_pkg::SLOT_W-1:0]   out_slot,
  output logic [rbol_pkg::HANDLE_W-1:0] out_found_handle,
  output logic [rbol_pkg::SIZE_W-1:0]   out_found_size,
  output logic [rbol_pkg::SIZE_W-1:0]   out_byte_offset,
  output logic                          out_evicted,
  output logic [rbol_pkg::HANDLE_W-1:0] out_evicted_handle
);

  rbol_pkg::cmd_t  cmd;
  rbol_pkg::stat_t stat;

  rbol_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  rbol_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operation       (in_operation),
    .in_entry_handle    (in_entry_handle),
    .in_entry_size      (in_entry_size),
    .in_lookup_offset   (in_lookup_offset),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hit            (out_hit),
    .out_slot           (out_slot),
    .out_found_handle   (out_found_handle),
    .out_found_size     (out_found_size),
    .out_byte_offset    (out_byte_offset),
    .out_evicted        (out_evicted),
    .out_evicted_handle (out_evicted_handle)
  );

endmodule

### rtl/rbol_chk.sv
// Port-level checker for ring_buffer_offset_lookup, attached with bind.
// Depends on rbol_pkg for field widths.
module rbol_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_hit,
  input logic [rbol_pkg::SIZE_W-1:0]   out_found_size,
  input logic [rbol_pkg::SIZE_W-1:0]   out_byte_offset,
  input logic                          out_evicted,
  input logic [rbol_pkg::HANDLE_W-1:0] out_evicted_handle
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit)
      && $stable(out_byte_offset) && $stable(out_evicted_handle))
    else $error("stalled result changed");

  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  a_hit_in_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_byte_offset < out_found_size && !out_evicted)
    else $error("hit offset outside entry or mixed with eviction");

  a_evict_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_handle != '0 |-> out_evicted)
    else $error("evicted handle without eviction");

endmodule

bind ring_buffer_offset_lookup rbol_chk u_rbol_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_hit            (out_hit),
  .out_found_size     (out_found_size),
  .out_byte_offset    (out_byte_offset),
  .out_evicted        (out_evicted),
  .out_evicted_handle (out_evicted_handle)
);

### tb/tb_ring_buffer_offset_lookup.sv
`timescale 1ns / 100ps
// Self-checking testbench for ring_buffer_offset_lookup: directed table, then random adds/finds.
// Depends on rbol_pkg and the ring_buffer_offset_lookup RTL.
module tb_ring_buffer_offset_lookup;

  localparam int   HANDLE_W = rbol_pkg::HANDLE_W;
  localparam int   SIZE_W   = rbol_pkg::SIZE_W;
  localparam int   OFFS_W   = rbol_pkg::OFFS_W;
  localparam int   SLOT_W   = rbol_pkg::SLOT_W;
  localparam logic OP_ADD   = rbol_pkg::OP_ADD;
  localparam logic OP_FIND  = rbol_pkg::OP_FIND;

  localparam int RING_DEPTH  = 16;
  localparam int LONG_HOLD   = 150;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 133;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] found_handle;
    logic [SIZE_W-1:0]   found_size;
    logic [SIZE_W-1:0]   byte_offset;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
  } ring_result_t;

  typedef struct {
    logic                op;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [OFFS_W-1:0]   offset;
    int                  count;
    bit                  typed;
    ring_result_t        res;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_operation = OP_ADD;
  logic [HANDLE_W-1:0] in_entry_handle = '0;
  logic [SIZE_W-1:0]   in_entry_size = '0;
  logic [OFFS_W-1:0]   in_lookup_offset = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_hit;
  logic [SLOT_W-1:0]   out_slot;
  logic [HANDLE_W-1:0] out_found_handle;
  logic [SIZE_W-1:0]   out_found_size;
  logic [SIZE_W-1:0]   out_byte_offset;
  logic                out_evicted;
  logic [HANDLE_W-1:0] out_evicted_handle;

  // predictor state
  logic [HANDLE_W-1:0] handle_mem [RING_DEPTH];
  logic [SIZE_W-1:0]   size_mem [RING_DEPTH];
  logic [SLOT_W-1:0]   wr_idx;
  logic [SLOT_W-1:0]   rd_idx;
  logic                ring_full;

  ring_result_t pending_results[$];
  stim_row_t    directed_plan[$];
  int           mismatches = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           hold_ask = 1'b0;

  ring_buffer_offset_lookup #(.RING_DEPTH(RING_DEPTH)) dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void clear_ring();
    for (int i = 0; i < RING_DEPTH; i++) begin
      handle_mem[i] = '0;
      size_mem[i] = '0;
    end
    wr_idx = '0;
    rd_idx = '0;
    ring_full = 1'b0;
  endfunction

  // Applies one item to the predictor state and returns the result it gives.
  function automatic ring_result_t step_ring(logic op, logic [HANDLE_W-1:0] h,
                                             logic [SIZE_W-1:0] sz, logic [OFFS_W-1:0] off);
    ring_result_t r;
    logic [SLOT_W-1:0] pos;
    logic [OFFS_W:0] acc;
    bit done;
    r = '0;
    if (op == OP_ADD) begin
      if (ring_full) begin
        rd_idx = rd_idx + 1'b1;
        r.evicted = 1'b1;
        r.evicted_handle = handle_mem[wr_idx];
      end
      handle_mem[wr_idx] = h;
      size_mem[wr_idx] = sz;
      wr_idx = wr_idx + 1'b1;
      ring_full = (wr_idx == rd_idx);
    end else begin
      acc = '0;
      pos = rd_idx;
      done = 1'b0;
      for (int n = 0; n < RING_DEPTH && !done; n++) begin
        if (handle_mem[pos] == '0) begin
          done = 1'b1;
        end else if (acc + size_mem[pos] > off) begin
          r.hit = 1'b1;
          r.slot = pos;
          r.found_handle = handle_mem[pos];
          r.found_size = size_mem[pos];
          r.byte_offset = SIZE_W'(off - acc);
          done = 1'b1;
        end else begin
          acc = acc + size_mem[pos];
          pos = pos + 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Bytes reachable by a find right now (walk stops at the first null).
  function automatic int live_bytes();
    int total;
    logic [SLOT_W-1:0] pos;
    total = 0;
    pos = rd_idx;
    for (int n = 0; n < RING_DEPTH; n++) begin
      if (handle_mem[pos] == '0) break;
      total += size_mem[pos];
      pos = pos + 1'b1;
    end
    return total;
  endfunction

  function automatic ring_result_t found(int slot, logic [HANDLE_W-1:0] h,
                                         logic [SIZE_W-1:0] sz, logic [SIZE_W-1:0] bo);
    ring_result_t r;
    r = '0;
    r.hit = 1'b1;
    r.slot = SLOT_W'(slot);
    r.found_handle = h;
    r.found_size = sz;
    r.byte_offset = bo;
    return r;
  endfunction

  function automatic ring_result_t evict(logic [HANDLE_W-1:0] h);
    ring_result_t r;
    r = '0;
    r.evicted = 1'b1;
    r.evicted_handle = h;
    return r;
  endfunction

  function automatic void plan_row(logic op, logic [HANDLE_W-1:0] h, logic [SIZE_W-1:0] sz,
                                   logic [OFFS_W-1:0] off, int n, bit typed,
                                   ring_result_t res);
    stim_row_t row;
    row.op = op;
    row.handle = h;
    row.size = sz;
    row.offset = off;
    row.count = n;
    row.typed = typed;
    row.res = res;
    directed_plan.push_back(row);
  endfunction

  // Offers one item at the falling edge, holds it until accepted, then records
  // what the block should answer.
  task automatic offer_item(logic op, logic [HANDLE_W-1:0] h, logic [SIZE_W-1:0] sz,
                            logic [OFFS_W-1:0] off, bit typed, ring_result_t typed_res);
    ring_result_t want;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_entry_handle <= h;
    in_entry_size <= sz;
    in_lookup_offset <= off;
    do @(posedge clk); while (in_stall);
    want = step_ring(op, h, sz, off);
    pending_results.push_back(typed ? typed_res : want);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int n);
    logic op;
    logic [HANDLE_W-1:0] h;
    logic [SIZE_W-1:0] sz;
    logic [OFFS_W-1:0] off;
    int pick;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < 50) ? OP_FIND : OP_ADD;
      pick = $urandom_range(0, 99);
      if (pick < 4) h = '0;
      else if (pick < 8) h = '1;
      else h = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 10) sz = '0;
      else if (pick < 15) sz = '1;
      else if (pick < 25) sz = SIZE_W'($urandom);
      else sz = SIZE_W'($urandom_range(1, 200));
      if ($urandom_range(0, 99) < 15) off = OFFS_W'($urandom);
      else off = OFFS_W'($urandom_range(0, live_bytes() + 4));
      offer_item(op, h, sz, off, 1'b0, '0);
    end
  endtask

  // Result side: random stall, or one long hold-off when asked.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_ask) begin
        hold_ask = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  task automatic cmp(string name, logic [HANDLE_W-1:0] want, logic [HANDLE_W-1:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    ring_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, got hit=%0h evicted=%0h",
                 $time, out_hit, out_evicted);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        cmp("hit", want.hit, out_hit);
        cmp("slot", want.slot, out_slot);
        cmp("found_handle", want.found_handle, out_found_handle);
        cmp("found_size", want.found_size, out_found_size);
        cmp("byte_offset", want.byte_offset, out_byte_offset);
        cmp("evicted", want.evicted, out_evicted);
        cmp("evicted_handle", want.evicted_handle, out_evicted_handle);
      end
    end
  end

  initial begin
    clear_ring();
    // empty ring, extremes of size and offset
    plan_row(OP_FIND, '0, '0, '0, 1, 1'b1, '0);
    plan_row(OP_FIND, '0, '0, '1, 1, 1'b1, '0);
    plan_row(OP_ADD, '1, '1, '0, 1, 1'b1, '0);
    plan_row(OP_FIND, '0, '0, 20'h0, 1, 1'b1, found(0, '1, '1, 16'h0));
    plan_row(OP_FIND, '0, '0, 20'hFFFE, 1, 1'b1, found(0, '1, '1, 16'hFFFE));
    plan_row(OP_FIND, '0, '0, 20'hFFFF, 1, 1'b1, '0);
    // zero-length entry is skipped by the walk
    plan_row(OP_ADD, 32'h1, 16'h0, '0, 1, 1'b1, '0);
    plan_row(OP_ADD, 32'h8000_0000, 16'h1, '0, 1, 1'b1, '0);
    plan_row(OP_FIND, '0, '0, 20'hFFFF, 1, 1'b1, found(2, 32'h8000_0000, 16'h1, 16'h0));
    // null entry hides what follows it
    plan_row(OP_ADD, '0, 16'h5, '0, 1, 1'b1, '0);
    plan_row(OP_ADD, 32'h1234_5678, 16'd100, '0, 1, 1'b1, '0);
    plan_row(OP_FIND, '0, '0, 20'h10000, 1, 1'b1, '0);
    // fill the ring, then overwrite through the wrap, null eviction included
    plan_row(OP_ADD, 32'h100, 16'd3, '0, 11, 1'b0, '0);
    plan_row(OP_ADD, 32'hA5A5_A5A5, 16'd7, '0, 1, 1'b1, evict('1));
    plan_row(OP_ADD, 32'h200, 16'd2, '0, 2, 1'b0, '0);
    plan_row(OP_ADD, 32'h5A5A_5A5A, 16'd9, '0, 1, 1'b1, evict('0));
    plan_row(OP_FIND, '0, '0, 20'd0, 1, 1'b1, found(4, 32'h1234_5678, 16'd100, 16'd0));
    plan_row(OP_FIND, '0, '0, 20'd100, 1, 1'b0, '0);
    plan_row(OP_FIND, '0, '0, 20'd140, 1, 1'b0, '0);
    plan_row(OP_FIND, '0, '0, 20'd152, 1, 1'b0, '0);
    plan_row(OP_FIND, '0, '0, 20'd153, 1, 1'b0, '0);
    plan_row(OP_FIND, '0, '0, '1, 1, 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      for (int k = 0; k < directed_plan[i].count; k++) begin
        offer_item(directed_plan[i].op, directed_plan[i].handle + k, directed_plan[i].size,
                   directed_plan[i].offset, directed_plan[i].typed, directed_plan[i].res);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 70 : 0;
      recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 10 : 0;
      run_random(PHASE_ITEMS);
      if (phase == 0) hold_ask = 1'b1;
      if (phase == 1) wait_drained();
      run_random(PHASE_ITEMS);
    end

    wait_drained();
    repeat (RING_DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rbol_pkg.sv
rtl/rbol_ram.sv
rtl/rbol_ctrl.sv
rtl/rbol_dp.sv
rtl/ring_buffer_offset_lookup.sv
rtl/rbol_chk.sv
tb/tb_ring_buffer_offset_lookup.sv
